FILE: rtl/dot_bracket_pair_matcher_unit_defines.svh
// Assertion macros for the dot-bracket pair matcher.
// Included by the top level; expects clk and rst in scope.
`ifndef DOT_BRACKET_PAIR_MATCHER_UNIT_DEFINES_SVH
`define DOT_BRACKET_PAIR_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DBPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every edge including reset.
`define DBPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dbpm_pkg.sv
// Shared types and constants for the dot-bracket pair matcher.
// No dependencies; the interfaces and modules all use this package.
package dbpm_pkg;

  // Sizing of the string, of the two bracket stacks and of the command queue.
  localparam int MAX_LENGTH  = 1024;
  localparam int STACK_DEPTH = 512;
  localparam int QUEUE_DEPTH = 4;

  localparam int SYMBOL_W = 8;
  localparam int POS_W    = 10;
  localparam int COUNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

  // Structure characters.
  localparam logic [SYMBOL_W-1:0] CHAR_ROUND_OPEN   = 8'h28;
  localparam logic [SYMBOL_W-1:0] CHAR_ROUND_CLOSE  = 8'h29;
  localparam logic [SYMBOL_W-1:0] CHAR_SQUARE_OPEN  = 8'h5B;
  localparam logic [SYMBOL_W-1:0] CHAR_SQUARE_CLOSE = 8'h5D;

  // Result kinds.
  localparam logic KIND_PAIR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_UNCLOSED  = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_ROUND,
    OP_PUSH_SQUARE,
    OP_POP_ROUND,
    OP_POP_SQUARE
  } op_t;

  // One command from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [POS_W-1:0]  pos;
    logic              last;
    status_t           status;
  } cmd_t;

endpackage

FILE: rtl/dbpm_if.sv
// Valid/ready channel interfaces for input characters and results.
// Depends on dbpm_pkg for field widths.
interface dbpm_item_if;
  logic                           valid;
  logic                           ready;
  logic [dbpm_pkg::SYMBOL_W-1:0]  symbol;
  logic                           last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

interface dbpm_result_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [dbpm_pkg::POS_W-1:0]  open_position;
  logic [dbpm_pkg::POS_W-1:0]  close_position;
  logic [1:0]                  status;
  logic                        end_of_run;

  modport source (output valid, output result_kind, output open_position,
                  output close_position, output status, output end_of_run, input ready);
  modport sink (input valid, input result_kind, input open_position,
                input close_position, input status, input end_of_run, output ready);
endinterface

FILE: rtl/dbpm_front.sv
// Front end: accepts characters, tracks position, stack depths and error.
// Emits stack commands into the queue. Depends on dbpm_pkg and dbpm_if.
module dbpm_front (
  input  logic                clk,
  input  logic                rst,
  dbpm_item_if.sink           items,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output dbpm_pkg::cmd_t      cmd
);
  import dbpm_pkg::*;

  logic [COUNT_W-1:0] position_count, position_count_next;
  logic [DEPTH_W-1:0] round_depth, round_depth_next;
  logic [DEPTH_W-1:0] square_depth, square_depth_next;
  status_t            error_code, error_code_next;
  op_t                op;
  logic [ADDR_W-1:0]  addr;
  logic               accept;

  assign items.ready = cmd_ready;
  assign accept      = items.valid && cmd_ready;

  // Classify the character and work out the next run state.
  always_comb begin
    position_count_next = position_count;
    round_depth_next    = round_depth;
    square_depth_next   = square_depth;
    error_code_next     = error_code;
    op                  = OP_NONE;
    addr                = '0;
    if (error_code == ST_OK) begin
      if (position_count >= COUNT_W'(MAX_LENGTH)) begin
        error_code_next = ST_TOO_LONG;
      end else begin
        unique case (items.symbol)
          CHAR_ROUND_OPEN: begin
            if (round_depth >= DEPTH_W'(STACK_DEPTH)) begin
              error_code_next = ST_TOO_LONG;
            end else begin
              op               = OP_PUSH_ROUND;
              addr             = round_depth[ADDR_W-1:0];
              round_depth_next = round_depth + 1'b1;
            end
          end
          CHAR_SQUARE_OPEN: begin
            if (square_depth >= DEPTH_W'(STACK_DEPTH)) begin
              error_code_next = ST_TOO_LONG;
            end else begin
              op                = OP_PUSH_SQUARE;
              addr              = square_depth[ADDR_W-1:0];
              square_depth_next = square_depth + 1'b1;
            end
          end
          CHAR_ROUND_CLOSE: begin
            if (round_depth == '0) begin
              error_code_next = ST_UNMATCHED;
            end else begin
              op               = OP_POP_ROUND;
              round_depth_next = round_depth - 1'b1;
              addr             = round_depth_next[ADDR_W-1:0];
            end
          end
          CHAR_SQUARE_CLOSE: begin
            if (square_depth == '0) begin
              error_code_next = ST_UNMATCHED;
            end else begin
              op                = OP_POP_SQUARE;
              square_depth_next = square_depth - 1'b1;
              addr              = square_depth_next[ADDR_W-1:0];
            end
          end
          default: begin
            op = OP_NONE;
          end
        endcase
        if (error_code_next == ST_OK) begin
          position_count_next = position_count + 1'b1;
        end
      end
    end
  end

  // Build the command; only beats that touch a stack or end the string are queued.
  always_comb begin
    cmd.op   = op;
    cmd.addr = addr;
    cmd.pos  = POS_W'(position_count);
    cmd.last = items.last_symbol;
    if (error_code_next != ST_OK) begin
      cmd.status = error_code_next;
    end else if (round_depth_next != '0 || square_depth_next != '0) begin
      cmd.status = ST_UNCLOSED;
    end else begin
      cmd.status = ST_OK;
    end
    cmd_valid = items.valid && (op != OP_NONE || items.last_symbol);
  end

  // Run state; the last character returns everything to the start of a string.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      round_depth    <= '0;
      square_depth   <= '0;
      error_code     <= ST_OK;
    end else if (accept) begin
      if (items.last_symbol) begin
        position_count <= '0;
        round_depth    <= '0;
        square_depth   <= '0;
        error_code     <= ST_OK;
      end else begin
        position_count <= position_count_next;
        round_depth    <= round_depth_next;
        square_depth   <= square_depth_next;
        error_code     <= error_code_next;
      end
    end
  end

endmodule

FILE: rtl/dbpm_queue.sv
// Short command queue between front and back.
// Depends on dbpm_pkg for the command type and depth.
module dbpm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dbpm_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output dbpm_pkg::cmd_t out_cmd
);
  import dbpm_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != QCOUNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/dbpm_back.sv
// Back end: holds the two bracket stacks and drives the result channel.
// Depends on dbpm_pkg and dbpm_if.
module dbpm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  dbpm_pkg::cmd_t cmd,
  dbpm_result_if.source  results
);
  import dbpm_pkg::*;

  logic [POS_W-1:0] round_stack  [STACK_DEPTH];
  logic [POS_W-1:0] square_stack [STACK_DEPTH];
  logic [POS_W-1:0] round_rd;
  logic [POS_W-1:0] square_rd;

  logic             out_valid;
  logic             out_kind;
  logic             out_square;
  logic [POS_W-1:0] out_close;
  status_t          out_status;
  logic             out_end;
  logic             split_done, split_done_next;

  logic is_pop;
  logic has_out;
  logic slot_free;
  logic go;
  logic mem_op;

  // A pop with the last flag gives two beats: the pair, then the status.
  assign is_pop    = (cmd.op == OP_POP_ROUND) || (cmd.op == OP_POP_SQUARE);
  assign has_out   = is_pop || cmd.last;
  assign slot_free = !out_valid || results.ready;
  assign go        = cmd_valid && (slot_free || !has_out);
  assign mem_op    = go && !split_done;
  assign cmd_ready = go && !(is_pop && cmd.last && !split_done);

  always_comb begin
    split_done_next = split_done;
    if (cmd_ready) begin
      split_done_next = 1'b0;
    end else if (go) begin
      split_done_next = 1'b1;
    end
  end

  // Round stack: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_op && cmd.op == OP_PUSH_ROUND) begin
      round_stack[cmd.addr] <= cmd.pos;
    end
    if (mem_op && cmd.op == OP_POP_ROUND) begin
      round_rd <= round_stack[cmd.addr];
    end
  end

  // Square stack: same arrangement.
  always_ff @(posedge clk) begin
    if (mem_op && cmd.op == OP_PUSH_SQUARE) begin
      square_stack[cmd.addr] <= cmd.pos;
    end
    if (mem_op && cmd.op == OP_POP_SQUARE) begin
      square_rd <= square_stack[cmd.addr];
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      split_done <= 1'b0;
    end else begin
      split_done <= split_done_next;
      if (go && has_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (go && has_out) begin
      if (is_pop && !split_done) begin
        out_kind   <= KIND_PAIR;
        out_square <= (cmd.op == OP_POP_SQUARE);
        out_close  <= cmd.pos;
        out_status <= ST_OK;
        out_end    <= !cmd.last;
      end else begin
        out_kind   <= KIND_STATUS;
        out_square <= 1'b0;
        out_close  <= '0;
        out_status <= cmd.status;
        out_end    <= 1'b1;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.result_kind    = out_kind;
  assign results.open_position  = (out_kind == KIND_PAIR) ? (out_square ? square_rd : round_rd)
                                                          : '0;
  assign results.close_position = out_close;
  assign results.status         = out_status;
  assign results.end_of_run     = out_end;

endmodule

FILE: rtl/dot_bracket_pair_matcher_unit.sv
// Dot-bracket pair matcher: takes one structure character per beat and
// returns base pairs and an end-of-string status. One character per cycle is
// accepted while the back end keeps up; a closing bracket that is also the last
// character gives two result beats, the pair then the status, and the four-entry command
// queue absorbs that. A closing bracket's command is first written into the queue;
// once it reaches the head, the stack read and the output register load on the
// same edge and the pair is presented at the result port. No clearing pass is
// needed after reset.
`include "dot_bracket_pair_matcher_unit_defines.svh"

module dot_bracket_pair_matcher_unit (
  input  logic          clk,
  input  logic          rst,
  dbpm_item_if.sink     items,
  dbpm_result_if.source results
);
  import dbpm_pkg::*;

  logic enq_valid;
  logic enq_ready;
  cmd_t enq_cmd;
  logic deq_valid;
  logic deq_ready;
  cmd_t deq_cmd;
  logic pair_beat;
  logic status_beat;
  logic stray_cmd;

  // Front end: classification and run state.
  dbpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd_valid (enq_valid),
    .cmd_ready (enq_ready),
    .cmd       (enq_cmd)
  );

  // Decoupling queue.
  dbpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (enq_valid),
    .in_ready  (enq_ready),
    .in_cmd    (enq_cmd),
    .out_valid (deq_valid),
    .out_ready (deq_ready),
    .out_cmd   (deq_cmd)
  );

  // Back end: stacks and result port.
  dbpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (deq_valid),
    .cmd_ready (deq_ready),
    .cmd       (deq_cmd),
    .results   (results)
  );

  // Terms used by the checks below.
  assign pair_beat   = results.valid && (results.result_kind == KIND_PAIR);
  assign status_beat = results.valid && (results.result_kind == KIND_STATUS);
  assign stray_cmd   = deq_valid && (deq_cmd.op == OP_NONE) && !deq_cmd.last;

  // A status beat always closes the run of results for its character.
  `DBPM_ASSERT_IMP(a_status_ends, status_beat, results.end_of_run, "status beat without end")
  // Pair beats carry no status, and no stray command waits at the queue head.
  `DBPM_ASSERT_IMP(a_pair_ok, pair_beat, results.status == ST_OK && !stray_cmd, "bad pair beat")
  // Nothing is presented right after reset.
  `DBPM_ASSERT_NEXT(a_reset_quiet, rst, !results.valid && !deq_valid, "valid after reset")

endmodule
